// ===== sv/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants for the RMC field extractor
// Parse phases, field codes, queue command format and default-text tables.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int unsigned TIME_CHARS_DEF   = 6;
  localparam int unsigned LAT_CHARS_DEF    = 9;
  localparam int unsigned LONG_CHARS_DEF   = 10;
  localparam int unsigned SPEED_CHARS_DEF  = 7;
  localparam int unsigned COURSE_CHARS_DEF = 7;
  localparam int unsigned DATE_CHARS_DEF   = 6;

  localparam logic [7:0] COMMA = 8'h2C;

  localparam logic [3:0] LAT_DEF_LEN  = 4'd9;
  localparam logic [3:0] LONG_DEF_LEN = 4'd10;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [4:0] {
    PH_HDR      = 5'd0,
    PH_TIME     = 5'd1,
    PH_TSKIP    = 5'd2,
    PH_STATUS   = 5'd3,
    PH_LAT      = 5'd4,
    PH_LATSKIP  = 5'd5,
    PH_LATHEM   = 5'd6,
    PH_LONG     = 5'd7,
    PH_LONGSKIP = 5'd8,
    PH_LONGHEM  = 5'd9,
    PH_SPEED    = 5'd10,
    PH_SPDSKIP  = 5'd11,
    PH_COURSE   = 5'd12,
    PH_CRSSKIP  = 5'd13,
    PH_DATE     = 5'd14,
    PH_DONE     = 5'd15
  } parse_phase_e;

  typedef enum logic [2:0] {
    FID_TIME   = 3'd0,
    FID_LAT    = 3'd1,
    FID_LONG   = 3'd2,
    FID_SPEED  = 3'd3,
    FID_COURSE = 3'd4,
    FID_DATE   = 3'd5,
    FID_END    = 3'd6
  } field_id_e;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_CHAR     = 2'd1,
    OP_LAT_DEF  = 2'd2,
    OP_LONG_DEF = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    field_id_e  field_id;
    logic [3:0] position;
    logic [7:0] character;
    logic       eos;
  } cmd_t;

  // "00.000000"
  function automatic logic [7:0] lat_default_char(input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h30;
    if (pos == 4'd2) ch = 8'h2E;
    return ch;
  endfunction

  // "000.000000"
  function automatic logic [7:0] long_default_char(input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h30;
    if (pos == 4'd3) ch = 8'h2E;
    return ch;
  endfunction

endpackage

// ===== sv/rmc_front.sv =====
// ----------------------------------------------------------------------------
// rmc_front: sentence parser front end
// Tracks the comma-counting parse phase and turns each byte into one
// queue command (a character, a default run, an end record, or nothing).
// ----------------------------------------------------------------------------
module rmc_front #(
  parameter int unsigned TIME_CHARS   = rmc_pkg::TIME_CHARS_DEF,
  parameter int unsigned LAT_CHARS    = rmc_pkg::LAT_CHARS_DEF,
  parameter int unsigned LONG_CHARS   = rmc_pkg::LONG_CHARS_DEF,
  parameter int unsigned SPEED_CHARS  = rmc_pkg::SPEED_CHARS_DEF,
  parameter int unsigned COURSE_CHARS = rmc_pkg::COURSE_CHARS_DEF,
  parameter int unsigned DATE_CHARS   = rmc_pkg::DATE_CHARS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_sentence_i,
  input  logic          q_full_i,
  output logic          push_o,
  output rmc_pkg::cmd_t push_cmd_o
);

  rmc_pkg::parse_phase_e phase_q, phase_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [4:0]            cnt_inc;
  logic [4:0]            lim;
  logic                  lim_hit;
  logic                  comma;
  logic                  accept;
  rmc_pkg::cmd_t         cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign comma      = (data_byte_i == rmc_pkg::COMMA);
  assign cnt_inc    = {1'b0, cnt_q} + 5'd1;

  always_comb begin
    case (phase_q)
      rmc_pkg::PH_TIME:   lim = 5'(TIME_CHARS);
      rmc_pkg::PH_LAT:    lim = 5'(LAT_CHARS);
      rmc_pkg::PH_LONG:   lim = 5'(LONG_CHARS);
      rmc_pkg::PH_SPEED:  lim = 5'(SPEED_CHARS);
      rmc_pkg::PH_COURSE: lim = 5'(COURSE_CHARS);
      rmc_pkg::PH_DATE:   lim = 5'(DATE_CHARS);
      default:            lim = 5'd16;
    endcase
  end

  assign lim_hit = (cnt_inc >= lim);

  always_comb begin
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    cmd.op        = rmc_pkg::OP_NONE;
    cmd.field_id  = rmc_pkg::FID_TIME;
    cmd.position  = cnt_q;
    cmd.character = data_byte_i;
    cmd.eos       = end_of_sentence_i;

    case (phase_q)
      rmc_pkg::PH_HDR: begin
        if (comma) phase_d = rmc_pkg::PH_TIME;
      end
      rmc_pkg::PH_TIME, rmc_pkg::PH_DATE: begin
        // fixed window: commas are captured as data
        cmd.op       = rmc_pkg::OP_CHAR;
        cmd.field_id = (phase_q == rmc_pkg::PH_TIME) ? rmc_pkg::FID_TIME
                                                      : rmc_pkg::FID_DATE;
        cnt_d        = cnt_inc[3:0];
        if (lim_hit) begin
          phase_d = (phase_q == rmc_pkg::PH_TIME) ? rmc_pkg::PH_TSKIP
                                                   : rmc_pkg::PH_DONE;
          cnt_d   = 4'd0;
        end
      end
      rmc_pkg::PH_TSKIP: begin
        if (comma) phase_d = rmc_pkg::PH_STATUS;
      end
      rmc_pkg::PH_STATUS: begin
        if (comma) phase_d = rmc_pkg::PH_LAT;
      end
      rmc_pkg::PH_LAT: begin
        if (comma) begin
          if (cnt_q == 4'd0) cmd.op = rmc_pkg::OP_LAT_DEF;
          phase_d = rmc_pkg::PH_LATHEM;
          cnt_d   = 4'd0;
        end else begin
          cmd.op       = rmc_pkg::OP_CHAR;
          cmd.field_id = rmc_pkg::FID_LAT;
          cnt_d        = cnt_inc[3:0];
          if (lim_hit) begin
            phase_d = rmc_pkg::PH_LATSKIP;
            cnt_d   = 4'd0;
          end
        end
      end
      rmc_pkg::PH_LATSKIP: begin
        if (comma) phase_d = rmc_pkg::PH_LATHEM;
      end
      rmc_pkg::PH_LATHEM: begin
        if (comma) phase_d = rmc_pkg::PH_LONG;
      end
      rmc_pkg::PH_LONG: begin
        if (comma) begin
          if (cnt_q == 4'd0) cmd.op = rmc_pkg::OP_LONG_DEF;
          phase_d = rmc_pkg::PH_LONGHEM;
          cnt_d   = 4'd0;
        end else begin
          cmd.op       = rmc_pkg::OP_CHAR;
          cmd.field_id = rmc_pkg::FID_LONG;
          cnt_d        = cnt_inc[3:0];
          if (lim_hit) begin
            phase_d = rmc_pkg::PH_LONGSKIP;
            cnt_d   = 4'd0;
          end
        end
      end
      rmc_pkg::PH_LONGSKIP: begin
        if (comma) phase_d = rmc_pkg::PH_LONGHEM;
      end
      rmc_pkg::PH_LONGHEM: begin
        if (comma) phase_d = rmc_pkg::PH_SPEED;
      end
      rmc_pkg::PH_SPEED, rmc_pkg::PH_COURSE: begin
        if (comma) begin
          phase_d = (phase_q == rmc_pkg::PH_SPEED) ? rmc_pkg::PH_COURSE
                                                    : rmc_pkg::PH_DATE;
          cnt_d   = 4'd0;
        end else begin
          cmd.op       = rmc_pkg::OP_CHAR;
          cmd.field_id = (phase_q == rmc_pkg::PH_SPEED) ? rmc_pkg::FID_SPEED
                                                         : rmc_pkg::FID_COURSE;
          cnt_d        = cnt_inc[3:0];
          if (lim_hit) begin
            phase_d = (phase_q == rmc_pkg::PH_SPEED) ? rmc_pkg::PH_SPDSKIP
                                                      : rmc_pkg::PH_CRSSKIP;
            cnt_d   = 4'd0;
          end
        end
      end
      rmc_pkg::PH_SPDSKIP: begin
        if (comma) phase_d = rmc_pkg::PH_COURSE;
      end
      rmc_pkg::PH_CRSSKIP: begin
        if (comma) phase_d = rmc_pkg::PH_DATE;
      end
      default: begin
        // done: ignore bytes until the sentence ends
      end
    endcase

    if (end_of_sentence_i) begin
      phase_d = rmc_pkg::PH_HDR;
      cnt_d   = 4'd0;
    end
  end

  // drop bytes that produce no result
  assign push_o     = accept && ((cmd.op != rmc_pkg::OP_NONE) || cmd.eos);
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rmc_pkg::PH_HDR;
      cnt_q   <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/rmc_queue.sv =====
// ----------------------------------------------------------------------------
// rmc_queue: command queue between parser and result sequencer
// Small register FIFO so the front and the back stall independently.
// ----------------------------------------------------------------------------
module rmc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rmc_pkg::cmd_t head_o
);

  rmc_pkg::cmd_t                 mem_q [rmc_pkg::QUEUE_DEPTH];
  logic [rmc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rmc_pkg::QPTR_W:0]      count_q;

  assign full_o  = (count_q == (rmc_pkg::QPTR_W+1)'(rmc_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty command queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (rmc_pkg::QPTR_W+1)'(rmc_pkg::QUEUE_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== sv/rmc_back.sv =====
// ----------------------------------------------------------------------------
// rmc_back: result sequencer
// Expands the queue head into results: one character or a default text run,
// and/or an end record, flagging the final result of each byte.
// ----------------------------------------------------------------------------
module rmc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rmc_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    field_id_o,
  output logic [3:0]    position_o,
  output logic [7:0]    character_o,
  output logic          run_last_o
);

  logic [3:0] idx_q;
  logic [3:0] body_len;
  logic       in_body;
  logic       fire;

  always_comb begin
    case (head_i.op)
      rmc_pkg::OP_CHAR:     body_len = 4'd1;
      rmc_pkg::OP_LAT_DEF:  body_len = rmc_pkg::LAT_DEF_LEN;
      rmc_pkg::OP_LONG_DEF: body_len = rmc_pkg::LONG_DEF_LEN;
      default:              body_len = 4'd0;
    endcase
  end

  assign in_body     = (idx_q < body_len);
  assign out_valid_o = !q_empty_i;
  assign fire        = out_valid_o && out_ready_i;

  always_comb begin
    field_id_o  = 3'(rmc_pkg::FID_END);
    position_o  = 4'd0;
    character_o = 8'd0;
    if (in_body) begin
      case (head_i.op)
        rmc_pkg::OP_LAT_DEF: begin
          field_id_o  = 3'(rmc_pkg::FID_LAT);
          position_o  = idx_q;
          character_o = rmc_pkg::lat_default_char(idx_q);
        end
        rmc_pkg::OP_LONG_DEF: begin
          field_id_o  = 3'(rmc_pkg::FID_LONG);
          position_o  = idx_q;
          character_o = rmc_pkg::long_default_char(idx_q);
        end
        default: begin
          field_id_o  = 3'(head_i.field_id);
          position_o  = head_i.position;
          character_o = head_i.character;
        end
      endcase
    end
  end

  assign run_last_o = !in_body || ((idx_q == body_len - 4'd1) && !head_i.eos);
  assign pop_o      = fire && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
    end else if (fire) begin
      idx_q <= run_last_o ? 4'd0 : idx_q + 4'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= rmc_pkg::LONG_DEF_LEN)
    else $error("run index out of range");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_id_o == 3'(rmc_pkg::FID_END)) |-> run_last_o)
    else $error("end record not flagged as last");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !run_last_o |=> out_valid_o && (idx_q != 4'd0))
    else $error("result run broken before its last result");

endmodule

// ===== sv/nmea_rmc_field_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_field_extractor_unit: RMC sentence field tagger
// Tags time, position, speed, course and date characters of an RMC
// sentence by comma counting, with default text for empty coordinates.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | in_valid_i/in_ready_o   | data_byte_i, end_of_sentence_i
//  out      | output    | out_valid_o/out_ready_i | field_id_o, position_o,
//           |           |                         | character_o, run_last_o
//
//  One byte is accepted per cycle while the four-entry command queue has room.
//  A byte that opens an empty coordinate yields a run of 9 or 10 results
//  (plus one for an end record), so the output sequencer sets the rate during
//  default runs. Bytes that produce no result never enter the queue.
//  Reset returns the parser to header skip and empties the queue.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor_unit #(
  parameter int unsigned TIME_CHARS   = rmc_pkg::TIME_CHARS_DEF,
  parameter int unsigned LAT_CHARS    = rmc_pkg::LAT_CHARS_DEF,
  parameter int unsigned LONG_CHARS   = rmc_pkg::LONG_CHARS_DEF,
  parameter int unsigned SPEED_CHARS  = rmc_pkg::SPEED_CHARS_DEF,
  parameter int unsigned COURSE_CHARS = rmc_pkg::COURSE_CHARS_DEF,
  parameter int unsigned DATE_CHARS   = rmc_pkg::DATE_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_sentence_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] field_id_o,
  output logic [3:0] position_o,
  output logic [7:0] character_o,
  output logic       run_last_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  rmc_pkg::cmd_t push_cmd;
  rmc_pkg::cmd_t head;

  rmc_front #(
    .TIME_CHARS   (TIME_CHARS),
    .LAT_CHARS    (LAT_CHARS),
    .LONG_CHARS   (LONG_CHARS),
    .SPEED_CHARS  (SPEED_CHARS),
    .COURSE_CHARS (COURSE_CHARS),
    .DATE_CHARS   (DATE_CHARS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_sentence_i (end_of_sentence_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .push_cmd_o        (push_cmd)
  );

  rmc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  rmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .field_id_o  (field_id_o),
    .position_o  (position_o),
    .character_o (character_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== tb/rmc_tag_checker.sv =====
// ----------------------------------------------------------------------------
// rmc_tag_checker: result predictor and comparator for the RMC field tagger
// Watches both channels, tags each accepted byte with its own copy of the
// comma-counting parser and checks every result transaction in order.
// ----------------------------------------------------------------------------
module rmc_tag_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_sentence_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] field_id_i,
  input  logic [3:0] position_i,
  input  logic [7:0] character_i,
  input  logic       run_last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         hit_bytes_o,
  output int         results_o,
  output int         sentences_o,
  output int         default_runs_o
);

  localparam logic [7:0] ZERO_CH   = 8'h30;
  localparam logic [7:0] DOT_CH    = 8'h2E;
  localparam int         PRINT_CAP = 40;

  typedef struct {
    rmc_pkg::field_id_e id;
    logic [3:0]         pos;
    logic [7:0]         ch;
    logic               last;
  } tag_t;

  tag_t                  tag_q[$];
  rmc_pkg::parse_phase_e phase = rmc_pkg::PH_HDR;
  logic [3:0]            taken = '0;

  int fail_count;
  int hit_bytes;
  int results;
  int sentences;
  int default_runs;

  assign fail_count_o   = fail_count;
  assign pending_o      = tag_q.size();
  assign hit_bytes_o    = hit_bytes;
  assign results_o      = results;
  assign sentences_o    = sentences;
  assign default_runs_o = default_runs;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] result %0d: %s", $time, results, msg);
    fail_count++;
  endtask

  function automatic void enter(input rmc_pkg::parse_phase_e p);
    phase = p;
    taken = '0;
  endfunction

  function automatic void push_tag(input rmc_pkg::field_id_e id, input logic [3:0] pos,
                                   input logic [7:0] ch);
    tag_t t;
    t.id   = id;
    t.pos  = pos;
    t.ch   = ch;
    t.last = 1'b0;
    tag_q.push_back(t);
  endfunction

  // Fixed window: every byte is data, commas included.
  function automatic void take_window(input rmc_pkg::field_id_e id, input int unsigned lim,
                                      input rmc_pkg::parse_phase_e nxt,
                                      input logic [7:0] b);
    push_tag(id, taken, b);
    taken = taken + 4'd1;
    if (taken >= lim || taken == 4'd0) enter(nxt);
  endfunction

  // Bounded field: a comma closes it, a full field skips to the next comma.
  function automatic void take_upto(input rmc_pkg::field_id_e id, input int unsigned lim,
                                    input rmc_pkg::parse_phase_e skip,
                                    input rmc_pkg::parse_phase_e nxt,
                                    input logic [7:0] b);
    if (b == rmc_pkg::COMMA) begin
      enter(nxt);
      return;
    end
    push_tag(id, taken, b);
    taken = taken + 4'd1;
    if (taken >= lim || taken == 4'd0) enter(skip);
  endfunction

  function automatic void push_default(input rmc_pkg::field_id_e id, input int unsigned len,
                                       input int unsigned dot_at);
    for (int unsigned i = 0; i < len; i++) begin
      push_tag(id, 4'(i), (i == dot_at) ? DOT_CH : ZERO_CH);
    end
    default_runs++;
  endfunction

  function automatic void tag_byte(input logic [7:0] b, input logic eos);
    int unsigned before_n;
    before_n = tag_q.size();
    case (phase)
      rmc_pkg::PH_HDR:      if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_TIME);
      rmc_pkg::PH_TIME:     take_window(rmc_pkg::FID_TIME, rmc_pkg::TIME_CHARS_DEF,
                                        rmc_pkg::PH_TSKIP, b);
      rmc_pkg::PH_TSKIP:    if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_STATUS);
      rmc_pkg::PH_STATUS:   if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_LAT);
      rmc_pkg::PH_LAT: begin
        if (b == rmc_pkg::COMMA && taken == 4'd0) begin
          push_default(rmc_pkg::FID_LAT, rmc_pkg::LAT_DEF_LEN, 2);
          enter(rmc_pkg::PH_LATHEM);
        end else begin
          take_upto(rmc_pkg::FID_LAT, rmc_pkg::LAT_CHARS_DEF, rmc_pkg::PH_LATSKIP,
                    rmc_pkg::PH_LATHEM, b);
        end
      end
      rmc_pkg::PH_LATSKIP:  if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_LATHEM);
      rmc_pkg::PH_LATHEM:   if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_LONG);
      rmc_pkg::PH_LONG: begin
        if (b == rmc_pkg::COMMA && taken == 4'd0) begin
          push_default(rmc_pkg::FID_LONG, rmc_pkg::LONG_DEF_LEN, 3);
          enter(rmc_pkg::PH_LONGHEM);
        end else begin
          take_upto(rmc_pkg::FID_LONG, rmc_pkg::LONG_CHARS_DEF, rmc_pkg::PH_LONGSKIP,
                    rmc_pkg::PH_LONGHEM, b);
        end
      end
      rmc_pkg::PH_LONGSKIP: if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_LONGHEM);
      rmc_pkg::PH_LONGHEM:  if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_SPEED);
      rmc_pkg::PH_SPEED:    take_upto(rmc_pkg::FID_SPEED, rmc_pkg::SPEED_CHARS_DEF,
                                      rmc_pkg::PH_SPDSKIP, rmc_pkg::PH_COURSE, b);
      rmc_pkg::PH_SPDSKIP:  if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_COURSE);
      rmc_pkg::PH_COURSE:   take_upto(rmc_pkg::FID_COURSE, rmc_pkg::COURSE_CHARS_DEF,
                                      rmc_pkg::PH_CRSSKIP, rmc_pkg::PH_DATE, b);
      rmc_pkg::PH_CRSSKIP:  if (b == rmc_pkg::COMMA) enter(rmc_pkg::PH_DATE);
      rmc_pkg::PH_DATE:     take_window(rmc_pkg::FID_DATE, rmc_pkg::DATE_CHARS_DEF,
                                        rmc_pkg::PH_DONE, b);
      default: ;
    endcase
    if (eos) begin
      push_tag(rmc_pkg::FID_END, 4'd0, 8'h00);
      enter(rmc_pkg::PH_HDR);
      sentences++;
    end
    if (tag_q.size() > before_n) begin
      tag_q[tag_q.size() - 1].last = 1'b1;
      hit_bytes++;
    end
  endfunction

  task automatic check_result();
    tag_t t;
    if (tag_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result field_id %0d position %0d char 0x%02h",
                                field_id_i, position_i, character_i));
    end else begin
      t = tag_q.pop_front();
      if (field_id_i !== t.id)
        report_mismatch($sformatf("field_id %0d, expected %0d", field_id_i, t.id));
      if (position_i !== t.pos)
        report_mismatch($sformatf("position %0d, expected %0d", position_i, t.pos));
      if (character_i !== t.ch)
        report_mismatch($sformatf("character 0x%02h, expected 0x%02h", character_i, t.ch));
      if (run_last_i !== t.last)
        report_mismatch($sformatf("run_last %0b, expected %0b", run_last_i, t.last));
    end
    results++;
  endtask

  // Input first, so a same-edge result would still find its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q.delete();
      enter(rmc_pkg::PH_HDR);
    end else begin
      if (in_valid_i && in_ready_i) tag_byte(data_byte_i, end_of_sentence_i);
      if (out_valid_i && out_ready_i) check_result();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the RMC field tagger
// Feeds directed corner sentences, then random well-formed, truncated and
// noisy RMC sentences under random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 480;
  localparam int CALM_START    = 160;
  localparam int CALM_END      = 320;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 16;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       eos       = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] field_id;
  logic [3:0] position;
  logic [7:0] character;
  logic       run_last;

  int fail_count, pending, hit_bytes, results, sentences, default_runs;
  int cycle_count;
  int bytes_sent;

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;

  logic [7:0] line_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nmea_rmc_field_extractor_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .end_of_sentence_i(eos),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .field_id_o       (field_id),
    .position_o       (position),
    .character_o      (character),
    .run_last_o       (run_last)
  );

  rmc_tag_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .end_of_sentence_i(eos),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .field_id_i       (field_id),
    .position_i       (position),
    .character_i      (character),
    .run_last_i       (run_last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .hit_bytes_o      (hit_bytes),
    .results_o        (results),
    .sentences_o      (sentences),
    .default_runs_o   (default_runs)
  );

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(idle_en && $urandom_range(0, 99) < 8);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(0, 99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    eos       = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] field_char();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 8) return 8'h2E;
    do b = 8'($urandom); while (b == rmc_pkg::COMMA);
    return b;
  endfunction

  function automatic void put_field(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) line_q.push_back(field_char());
  endfunction

  // Empty about a quarter of the time, else any length up to max_len.
  function automatic void put_coord(input int unsigned max_len);
    if ($urandom_range(0, 3) == 0) put_field(0);
    else put_field($urandom_range(1, max_len));
    line_q.push_back(rmc_pkg::COMMA);
  endfunction

  function automatic void build_rmc();
    line_q.delete();
    if ($urandom_range(0, 9) < 8) put_text("$GPRMC");
    else put_field($urandom_range(0, 6));
    line_q.push_back(rmc_pkg::COMMA);
    put_field(($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 9);
    line_q.push_back(rmc_pkg::COMMA);
    put_field($urandom_range(0, 2));
    line_q.push_back(rmc_pkg::COMMA);
    put_coord(13);
    put_field($urandom_range(0, 1));
    line_q.push_back(rmc_pkg::COMMA);
    put_coord(14);
    put_field($urandom_range(0, 1));
    line_q.push_back(rmc_pkg::COMMA);
    put_field($urandom_range(0, 10));
    line_q.push_back(rmc_pkg::COMMA);
    put_field($urandom_range(0, 10));
    line_q.push_back(rmc_pkg::COMMA);
    put_field($urandom_range(0, 9));
    if ($urandom_range(0, 1)) begin
      put_text(",,,A*");
      put_field(2);
    end
    // cut a sentence short now and then
    if ($urandom_range(0, 9) == 0) line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
  endfunction

  function automatic void build_noise();
    int unsigned len;
    len = $urandom_range(1, 30);
    line_q.delete();
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 3) line_q.push_back(rmc_pkg::COMMA);
      else line_q.push_back(8'($urandom));
    end
  endfunction

  initial begin : stimulus
    int n;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Commas, 0x00 and 0xFF inside the time window, both coordinates empty,
    // and the sentence ended on the comma that opens the longitude default.
    line_q.delete();
    line_q.push_back(rmc_pkg::COMMA);
    line_q.push_back(rmc_pkg::COMMA);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(rmc_pkg::COMMA);
    put_text("12");
    put_text(",,,,,");
    send_line();

    // End record alone, straight from header skip.
    line_q.delete();
    line_q.push_back(8'hFF);
    send_line();

    // Time window of commas only, then a zero byte ends it in the skip phase.
    line_q.delete();
    put_text(",,,,,,,");
    line_q.push_back(8'h00);
    send_line();

    n = 0;
    while (bytes_sent < ITEM_TARGET) begin
      idle_en = !(bytes_sent >= CALM_START && bytes_sent < CALM_END);
      if (n == 1) hold_req = 1'b1;
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_rmc();
      send_line();
      n++;
    end
    in_valid = 1'b0;
    eos      = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d bytes in %0d sentences, %0d of them tagged", bytes_sent, sentences,
             hit_bytes);
    $display("checked %0d results, %0d default coordinate runs, %0d cycles", results,
             default_runs, cycle_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rmc_pkg.sv
sv/rmc_front.sv
sv/rmc_queue.sv
sv/rmc_back.sv
sv/nmea_rmc_field_extractor_unit.sv
tb/rmc_tag_checker.sv
tb/tb.sv
